// ----- rtl/biquad_cascade_filter_defines.svh -----
// Assertion macros shared by the biquad cascade RTL.
// No dependencies; included by the files that carry concurrent assertions.
`ifndef BIQUAD_CASCADE_FILTER_DEFINES_SVH
`define BIQUAD_CASCADE_FILTER_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define BQC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the next cycle.
`define BQC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Condition must never hold.
`define BQC_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

// ----- rtl/bqc_pkg.sv -----
// Shared types and constants for the biquad cascade filter.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package bqc_pkg;

    // Fixed formats: Q2.14 coefficients, Q2.30 delay state.
    localparam int COEF_W     = 16;
    localparam int STATE_W    = 32;
    localparam int ACC_W      = 50;
    localparam int LANE_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int NUM_REGS   = 5;

    // Register indexes, also used to pick a coefficient kind.
    localparam logic [CFG_IDX_W-1:0] REG_B0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_B1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_B2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_A1 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_A2 = 3'd4;

    // Unity gain b0 in every lane.
    localparam logic [CFG_DATA_W-1:0] B0_RESET = 64'h4000_4000_4000_4000;

    // Datapath operations.
    localparam int OP_W = 3;
    localparam logic [OP_W-1:0] OP_NONE    = 3'd0;
    localparam logic [OP_W-1:0] OP_LOAD    = 3'd1;
    localparam logic [OP_W-1:0] OP_Y       = 3'd2;
    localparam logic [OP_W-1:0] OP_A1_INIT = 3'd3;
    localparam logic [OP_W-1:0] OP_A1_SUB  = 3'd4;
    localparam logic [OP_W-1:0] OP_A2_INIT = 3'd5;
    localparam logic [OP_W-1:0] OP_WR      = 3'd6;

    // Multiplier sample operand sources.
    localparam int SRC_W = 2;
    localparam logic [SRC_W-1:0] SRC_IN = 2'd0;
    localparam logic [SRC_W-1:0] SRC_X  = 2'd1;
    localparam logic [SRC_W-1:0] SRC_Y  = 2'd2;

    // Control from the sequencer to the datapath.
    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [SRC_W-1:0] src;
    } dp_ctrl_t;

endpackage

// ----- rtl/bqc_coef_regs.sv -----
// Coefficient register file with lane selection by section and kind.
// Depends on bqc_pkg.
`timescale 1ns / 1ps

module bqc_coef_regs (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           wr_en,
    input  logic [bqc_pkg::CFG_IDX_W-1:0]  wr_index,
    input  logic [bqc_pkg::CFG_DATA_W-1:0] wr_data,
    input  logic [bqc_pkg::CFG_IDX_W-1:0]  kind,
    input  logic [bqc_pkg::LANE_W-1:0]     lane,
    output logic signed [bqc_pkg::COEF_W-1:0] coef
);
    import bqc_pkg::*;

    logic [CFG_DATA_W-1:0] b0_reg;
    logic [CFG_DATA_W-1:0] b1_reg;
    logic [CFG_DATA_W-1:0] b2_reg;
    logic [CFG_DATA_W-1:0] a1_reg;
    logic [CFG_DATA_W-1:0] a2_reg;
    logic [CFG_DATA_W-1:0] word;
    logic [LANE_W+3:0]     lane_base;

    // Register writes; an index beyond the list is dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b0_reg <= B0_RESET;
            b1_reg <= '0;
            b2_reg <= '0;
            a1_reg <= '0;
            a2_reg <= '0;
        end else if (wr_en) begin
            case (wr_index)
                REG_B0:  b0_reg <= wr_data;
                REG_B1:  b1_reg <= wr_data;
                REG_B2:  b2_reg <= wr_data;
                REG_A1:  a1_reg <= wr_data;
                REG_A2:  a2_reg <= wr_data;
                default: ;
            endcase
        end
    end

    // Pick the register of the requested kind, then the section's lane.
    always_comb begin
        case (kind)
            REG_B0:  word = b0_reg;
            REG_B1:  word = b1_reg;
            REG_B2:  word = b2_reg;
            REG_A1:  word = a1_reg;
            REG_A2:  word = a2_reg;
            default: word = '0;
        endcase
    end

    assign lane_base = {lane, 4'b0000};
    assign coef      = word[lane_base +: COEF_W];

endmodule

// ----- rtl/bqc_state_mem.sv -----
// Delay state memory: one entry per section holding z2 and z1.
// Depends on bqc_pkg and the shared assertion macros.
`timescale 1ns / 1ps
`include "biquad_cascade_filter_defines.svh"

module bqc_state_mem #(
    parameter int DEPTH = 4,
    parameter int AW    = 2
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         rd_en,
    input  logic [AW-1:0]                rd_addr,
    output logic [bqc_pkg::STATE_W-1:0]  rd_z1,
    output logic [bqc_pkg::STATE_W-1:0]  rd_z2,
    input  logic                         wr_en,
    input  logic [AW-1:0]                wr_addr,
    input  logic [bqc_pkg::STATE_W-1:0]  wr_z1,
    input  logic [bqc_pkg::STATE_W-1:0]  wr_z2
);
    import bqc_pkg::*;

    logic [2*STATE_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]     valid_reg;
    logic [2*STATE_W-1:0] rd_data_reg;
    logic                 rd_hit_reg;

    // Write port; the valid bit marks the entry as holding real state.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= {wr_z2, wr_z1};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr_en) begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    // Registered read; data holds until the next read.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_hit_reg <= 1'b0;
        end else if (rd_en) begin
            rd_hit_reg <= valid_reg[rd_addr];
        end
    end

    // An entry not written since reset reads as zero.
    assign rd_z1 = rd_hit_reg ? rd_data_reg[STATE_W-1:0] : '0;
    assign rd_z2 = rd_hit_reg ? rd_data_reg[2*STATE_W-1:STATE_W] : '0;

    `BQC_ASSERT_NEVER(a_no_collision, aclk, aresetn,
        rd_en && wr_en && (rd_addr == wr_addr), "read and write hit the same entry")

endmodule

// ----- rtl/bqc_datapath.sv -----
// Shared multiplier and accumulators that evaluate one biquad section.
// Depends on bqc_pkg.
`timescale 1ns / 1ps

module bqc_datapath #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                aclk,
    input  bqc_pkg::dp_ctrl_t                   ctrl,
    input  logic signed [bqc_pkg::COEF_W-1:0]   coef,
    input  logic signed [SAMPLE_BITS-1:0]       sample_in,
    input  logic signed [bqc_pkg::STATE_W-1:0]  rd_z1,
    input  logic signed [bqc_pkg::STATE_W-1:0]  rd_z2,
    output logic signed [SAMPLE_BITS-1:0]       y,
    output logic signed [bqc_pkg::STATE_W-1:0]  wr_z1,
    output logic signed [bqc_pkg::STATE_W-1:0]  wr_z2
);
    import bqc_pkg::*;

    localparam int PROD_W = COEF_W + SAMPLE_BITS;
    localparam int ALIGN  = 31 - SAMPLE_BITS;
    localparam int YSH    = 45 - SAMPLE_BITS;
    localparam int ZSH    = 14;

    localparam logic signed [ACC_W-1:0] Y_MAX = (ACC_W'(1) << (SAMPLE_BITS - 1)) - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] Y_MIN = ~Y_MAX;
    localparam logic signed [ACC_W-1:0] Y_RND = ACC_W'(1) << (YSH - 1);
    localparam logic signed [ACC_W-1:0] Z_RND = ACC_W'(1) << (ZSH - 1);
    localparam logic signed [ACC_W-1:0] S_MAX = ACC_W'(32'h7FFF_FFFF);
    localparam logic signed [ACC_W-1:0] S_MIN = ~S_MAX;

    logic signed [SAMPLE_BITS-1:0] x_reg;
    logic signed [SAMPLE_BITS-1:0] y_reg;
    logic signed [SAMPLE_BITS-1:0] y_next;
    logic signed [SAMPLE_BITS-1:0] op_b;
    logic signed [PROD_W-1:0]      prod_reg;
    logic signed [ACC_W-1:0]       ps;
    logic signed [ACC_W-1:0]       z1s;
    logic signed [ACC_W-1:0]       z2s;
    logic signed [ACC_W-1:0]       ysum;
    logic signed [ACC_W-1:0]       yq;
    logic signed [ACC_W-1:0]       acc1_reg;
    logic signed [ACC_W-1:0]       acc2_reg;
    logic signed [ACC_W-1:0]       n2;

    // Shift out the rounding bits of a state sum and clamp to 32 bits.
    function automatic logic signed [STATE_W-1:0] sat_state(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] q;
        q = v >>> ZSH;
        if (q > S_MAX) begin
            return S_MAX[STATE_W-1:0];
        end else if (q < S_MIN) begin
            return S_MIN[STATE_W-1:0];
        end
        return q[STATE_W-1:0];
    endfunction

    // Sample operand of the multiplier.
    always_comb begin
        case (ctrl.src)
            SRC_IN:  op_b = sample_in;
            SRC_X:   op_b = x_reg;
            SRC_Y:   op_b = y_reg;
            default: op_b = x_reg;
        endcase
    end

    // One product per cycle, registered before any sum.
    always_ff @(posedge aclk) begin
        prod_reg <= coef * op_b;
    end

    // Product aligned to 44 fraction bits, state to the same scale.
    assign ps  = ACC_W'(prod_reg) <<< ALIGN;
    assign z1s = ACC_W'(rd_z1) <<< ZSH;
    assign z2s = ACC_W'(rd_z2) <<< ZSH;

    // Section output: round to sample precision and saturate.
    always_comb begin
        ysum = ps + z1s + Y_RND;
        yq   = ysum >>> YSH;
        if (yq > Y_MAX) begin
            y_next = Y_MAX[SAMPLE_BITS-1:0];
        end else if (yq < Y_MIN) begin
            y_next = Y_MIN[SAMPLE_BITS-1:0];
        end else begin
            y_next = yq[SAMPLE_BITS-1:0];
        end
    end

    assign n2 = acc2_reg - ps;

    // Accumulate the delay updates; the rounding half is folded in at start.
    always_ff @(posedge aclk) begin
        case (ctrl.op)
            OP_LOAD:    x_reg    <= sample_in;
            OP_Y:       y_reg    <= y_next;
            OP_A1_INIT: acc1_reg <= ps + z2s + Z_RND;
            OP_A1_SUB:  acc1_reg <= acc1_reg - ps;
            OP_A2_INIT: acc2_reg <= ps + Z_RND;
            OP_WR:      x_reg    <= y_reg;
            default:    ;
        endcase
    end

    assign y     = y_reg;
    assign wr_z1 = sat_state(acc1_reg);
    assign wr_z2 = sat_state(n2);

endmodule

// ----- rtl/biquad_cascade_filter.sv -----
// Top level of the biquad cascade filter: handshakes, sequencer and output register.
// Depends on bqc_pkg, bqc_coef_regs, bqc_state_mem, bqc_datapath and the macros.
//
//   Channel   Direction  Handshake           Payload
//   s_        in         s_tvalid/s_tready   s_tdata: sample_in
//   m_        out        m_tvalid/m_tready   m_tdata: sample_out
//   cfg_      in         cfg_valid/cfg_ready cfg_index, cfg_data (register write)
//
// Each section passes the steps Y, A1, B2, A2 and WR on the one shared multiplier, so the
// result is registered at the last write-back unless the output is still full, and can
// transfer in the idle state, when the next input is also taken; a new input waits for idle.
// Delay state lives in a small memory whose per-entry valid bits are cleared by reset.
// Reset is synchronous, active low; both ready outputs stay low while it is asserted.
// A result still waiting at the last write-back holds the sequencer until it transfers.
`timescale 1ns / 1ps
`include "biquad_cascade_filter_defines.svh"

module biquad_cascade_filter #(
    parameter int SECTIONS    = 4,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // s_tdata: sample_in in the low SAMPLE_BITS bits, zero padding above
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]     s_tdata,
    // m_tdata: sample_out in the low SAMPLE_BITS bits, zero padding above
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]     m_tdata,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [bqc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [bqc_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import bqc_pkg::*;

    localparam int TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int SEC_W   = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
    localparam logic [SEC_W-1:0] LAST_SEC = SEC_W'(SECTIONS - 1);

    // Sequencer states.
    localparam int ST_W = 3;
    localparam logic [ST_W-1:0] ST_IDLE = 3'd0;
    localparam logic [ST_W-1:0] ST_Y    = 3'd1;
    localparam logic [ST_W-1:0] ST_A1   = 3'd2;
    localparam logic [ST_W-1:0] ST_B2   = 3'd3;
    localparam logic [ST_W-1:0] ST_A2   = 3'd4;
    localparam logic [ST_W-1:0] ST_WR   = 3'd5;
    localparam logic [ST_W-1:0] ST_OUT  = 3'd6;

    logic [ST_W-1:0]            state_reg;
    logic [ST_W-1:0]            state_next;
    logic [SEC_W-1:0]           sec_reg;
    logic [SEC_W-1:0]           sec_next;
    logic [SEC_W-1:0]           sec_inc;
    logic [SEC_W-1:0]           coef_sec;
    logic [SEC_W-1:0]           rd_addr;
    logic                       rd_en;
    logic                       wr_en;
    logic                       out_load;
    logic                       out_free;
    logic                       m_tvalid_reg;
    logic [SAMPLE_BITS-1:0]     out_data_reg;
    logic [CFG_IDX_W-1:0]       kind;
    logic signed [COEF_W-1:0]   coef;
    dp_ctrl_t                   ctrl;
    logic [STATE_W-1:0]         rd_z1;
    logic [STATE_W-1:0]         rd_z2;
    logic [STATE_W-1:0]         wr_z1;
    logic [STATE_W-1:0]         wr_z2;
    logic signed [SAMPLE_BITS-1:0] y;

    assign cfg_ready = aresetn;
    assign s_tready  = aresetn && (state_reg == ST_IDLE);
    assign out_free  = !m_tvalid_reg || m_tready;
    assign sec_inc   = sec_reg + SEC_W'(1);

    bqc_coef_regs u_coef (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .kind     (kind),
        .lane     (LANE_W'(coef_sec)),
        .coef     (coef)
    );

    bqc_state_mem #(
        .DEPTH (SECTIONS),
        .AW    (SEC_W)
    ) u_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_z1   (rd_z1),
        .rd_z2   (rd_z2),
        .wr_en   (wr_en),
        .wr_addr (sec_reg),
        .wr_z1   (wr_z1),
        .wr_z2   (wr_z2)
    );

    bqc_datapath #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .aclk      (aclk),
        .ctrl      (ctrl),
        .coef      (coef),
        .sample_in (s_tdata[SAMPLE_BITS-1:0]),
        .rd_z1     (rd_z1),
        .rd_z2     (rd_z2),
        .y         (y),
        .wr_z1     (wr_z1),
        .wr_z2     (wr_z2)
    );

    // Sequencer: five steps per section; the write-back step also starts the
    // b0 product and the state read of the following section.
    always_comb begin
        state_next = state_reg;
        sec_next   = sec_reg;
        ctrl.op    = OP_NONE;
        ctrl.src   = SRC_X;
        kind       = REG_B0;
        coef_sec   = sec_reg;
        rd_en      = 1'b0;
        rd_addr    = sec_reg;
        wr_en      = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    ctrl.op    = OP_LOAD;
                    ctrl.src   = SRC_IN;
                    coef_sec   = '0;
                    rd_en      = 1'b1;
                    rd_addr    = '0;
                    sec_next   = '0;
                    state_next = ST_Y;
                end
            end
            ST_Y: begin
                ctrl.op    = OP_Y;
                ctrl.src   = SRC_X;
                kind       = REG_B1;
                state_next = ST_A1;
            end
            ST_A1: begin
                ctrl.op    = OP_A1_INIT;
                ctrl.src   = SRC_Y;
                kind       = REG_A1;
                state_next = ST_B2;
            end
            ST_B2: begin
                ctrl.op    = OP_A1_SUB;
                ctrl.src   = SRC_X;
                kind       = REG_B2;
                state_next = ST_A2;
            end
            ST_A2: begin
                ctrl.op    = OP_A2_INIT;
                ctrl.src   = SRC_Y;
                kind       = REG_A2;
                state_next = ST_WR;
            end
            ST_WR: begin
                ctrl.op = OP_WR;
                wr_en   = 1'b1;
                if (sec_reg != LAST_SEC) begin
                    ctrl.src   = SRC_Y;
                    coef_sec   = sec_inc;
                    rd_en      = 1'b1;
                    rd_addr    = sec_inc;
                    sec_next   = sec_inc;
                    state_next = ST_Y;
                end else if (out_free) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            sec_reg   <= '0;
        end else begin
            state_reg <= state_next;
            sec_reg   <= sec_next;
        end
    end

    // Output register: holds the result until its transfer completes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_data_reg <= y;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = TDATA_W'(out_data_reg);

    `BQC_ASSERT_NEXT(a_accept_starts, aclk, aresetn,
        s_tvalid && s_tready, state_reg == ST_Y, "accepted sample did not start section work")
    `BQC_ASSERT_SAME(a_result_source, aclk, aresetn,
        $rose(m_tvalid), ($past(state_reg) == ST_WR) || ($past(state_reg) == ST_OUT),
        "result appeared outside the final write-back")
    `BQC_ASSERT_NEVER(a_busy_no_ready, aclk, aresetn,
        s_tready && (sec_reg != sec_next) && (state_reg != ST_IDLE),
        "input ready while a section is in progress")

endmodule
